[sv/hira_pkg.sv]
package hira_pkg;

    // index geometry (depth is a power of two, home slot is the low key bits)
    localparam int SLOT_BITS   = 10;
    localparam int INDEX_DEPTH = 1 << SLOT_BITS;

    // field widths
    localparam int KEY_BITS   = 64;
    localparam int POS_BITS   = 24;
    localparam int ACT_BITS   = 7;
    localparam int LEN_BITS   = 8;
    localparam int STORE_BITS = 25;
    localparam int STAT_BITS  = 3;

    // record length clamp
    localparam logic [ACT_BITS-1:0] MAX_ACTIONS = ACT_BITS'(64);
    localparam logic [ACT_BITS-1:0] MIN_ACTIONS = ACT_BITS'(1);

    // configuration register indexes
    localparam logic CFG_STORE_WORDS = 1'b0;
    localparam logic CFG_ADDING_EN   = 1'b1;

    // result codes
    typedef enum logic [STAT_BITS-1:0] {
        ST_FOUND      = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_ABSENT     = 3'd2,
        ST_INDEX_FULL = 3'd3,
        ST_STORE_FULL = 3'd4
    } t_status;

    // one index slot: occupancy, record position and key
    typedef struct packed {
        logic                used;
        logic [POS_BITS-1:0] pos;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    // sequencer to allocator
    typedef struct packed {
        logic                commit;
        logic [LEN_BITS-1:0] len;
    } t_alloc_ctl;

    // allocator to sequencer
    typedef struct packed {
        logic                fits;
        logic [POS_BITS-1:0] pos;
    } t_alloc_sts;

endpackage

[sv/hira_slot_mem.sv]
module hira_slot_mem (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [hira_pkg::SLOT_BITS-1:0]  i_waddr,
    input  hira_pkg::t_entry                i_wdata,
    input  logic [hira_pkg::SLOT_BITS-1:0]  i_raddr,
    output hira_pkg::t_entry                o_rdata
);

    hira_pkg::t_entry r_mem [hira_pkg::INDEX_DEPTH];
    hira_pkg::t_entry r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/hira_alloc.sv]
module hira_alloc (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [hira_pkg::STORE_BITS-1:0]  i_store_words,
    input  hira_pkg::t_alloc_ctl             i_ctl,
    output hira_pkg::t_alloc_sts             o_sts
);

    localparam logic [hira_pkg::STORE_BITS-1:0] POS_SPAN =
        hira_pkg::STORE_BITS'(1) << hira_pkg::POS_BITS;

    logic [hira_pkg::STORE_BITS-1:0] r_next_free;
    logic [hira_pkg::STORE_BITS-1:0] n_next_free;
    logic [hira_pkg::STORE_BITS-1:0] w_limit;
    logic [hira_pkg::STORE_BITS:0]   w_end;

    // usable limit is the smaller of the store size and the position span
    assign w_limit = (i_store_words < POS_SPAN) ? i_store_words : POS_SPAN;

    // end of the candidate record against the limit
    assign w_end = {1'b0, r_next_free} + (hira_pkg::STORE_BITS + 1)'(i_ctl.len);

    assign o_sts.fits = (w_end <= {1'b0, w_limit});
    assign o_sts.pos  = r_next_free[hira_pkg::POS_BITS-1:0];

    // bump pointer advances on a committed insert
    always_comb begin
        n_next_free = r_next_free;
        if (i_ctl.commit) begin
            n_next_free = w_end[hira_pkg::STORE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
        end else begin
            r_next_free <= n_next_free;
        end
    end

endmodule

[sv/hash_index_record_allocator.sv]
// channel  dir  signals                       contents (lowest bit first)
// s        in   tvalid tready tdata tuser     tuser: func; tdata: key, action_count
// m        out  tvalid tready tdata tuser     tuser: status; tdata: position, slot,
//                                             probe_misses
// cfg      in   we addr wdata                 0 store_words, 1 adding_enabled
//
// after reset the index is swept empty, one slot a cycle, with s_tready low
// a request is accepted, then walks the index one slot per cycle on the
// single memory read port, then loads the result register
// the result register holds a finished beat while the next request is accepted
// a request stalls in S_DONE only if the previous result is still unread
module hash_index_record_allocator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request beats
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [71:0]                          i_s_tdata,  // key[63:0], action_count[70:64]
    input  logic                                 i_s_tuser,  // func
    // result beats
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [47:0]                          o_m_tdata,  // position[23:0], slot[33:24],
                                                             // probe_misses[43:34]
    output logic [hira_pkg::STAT_BITS-1:0]       o_m_tuser,  // status
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_addr,
    input  logic [hira_pkg::STORE_BITS-1:0]      i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_PROBE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [hira_pkg::SLOT_BITS-1:0] LAST_SLOT =
        hira_pkg::SLOT_BITS'(hira_pkg::INDEX_DEPTH - 1);

    t_state                               r_state, n_state;
    logic [hira_pkg::SLOT_BITS-1:0]       r_slot, n_slot;
    logic [hira_pkg::SLOT_BITS-1:0]       r_misses, n_misses;
    logic                                 r_func, n_func;
    logic [hira_pkg::KEY_BITS-1:0]        r_key, n_key;
    logic [hira_pkg::LEN_BITS-1:0]        r_len, n_len;
    hira_pkg::t_status                    r_status, n_status;
    logic [hira_pkg::POS_BITS-1:0]        r_pos, n_pos;
    logic [hira_pkg::STORE_BITS-1:0]      r_store_words;
    logic                                 r_adding_en;
    logic                                 r_out_valid, n_out_valid;
    logic [47:0]                          r_out_data, n_out_data;
    hira_pkg::t_status                    r_out_status, n_out_status;

    logic                                 w_accept;
    logic [hira_pkg::ACT_BITS-1:0]        w_acts_in;
    logic [hira_pkg::ACT_BITS-1:0]        w_acts;
    logic                                 w_we;
    logic [hira_pkg::SLOT_BITS-1:0]       w_waddr;
    hira_pkg::t_entry                     w_wdata;
    logic [hira_pkg::SLOT_BITS-1:0]       w_raddr;
    hira_pkg::t_entry                     w_entry;
    hira_pkg::t_alloc_ctl                 w_alloc_ctl;
    hira_pkg::t_alloc_sts                 w_alloc_sts;
    logic                                 w_out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // clamp the action count that sets the record length
    assign w_acts_in = i_s_tdata[70:64];
    always_comb begin
        priority if (w_acts_in < hira_pkg::MIN_ACTIONS) begin
            w_acts = hira_pkg::MIN_ACTIONS;
        end else if (w_acts_in > hira_pkg::MAX_ACTIONS) begin
            w_acts = hira_pkg::MAX_ACTIONS;
        end else begin
            w_acts = w_acts_in;
        end
    end

    // slot memory and record allocator
    hira_slot_mem u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_entry)
    );

    hira_alloc u_alloc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_store_words (r_store_words),
        .i_ctl         (w_alloc_ctl),
        .o_sts         (w_alloc_sts)
    );

    // read address: home slot on accept, following slot while probing
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = i_s_tdata[hira_pkg::SLOT_BITS-1:0];
            S_PROBE: w_raddr = r_slot + hira_pkg::SLOT_BITS'(1);
            default: w_raddr = r_slot;
        endcase
    end

    // sequencer: clear sweep, probe walk, result hand-off
    always_comb begin
        n_state          = r_state;
        n_slot           = r_slot;
        n_misses         = r_misses;
        n_func           = r_func;
        n_key            = r_key;
        n_len            = r_len;
        n_status         = r_status;
        n_pos            = r_pos;
        n_out_valid      = r_out_valid && !i_m_tready;
        n_out_data       = r_out_data;
        n_out_status     = r_out_status;
        w_we             = 1'b0;
        w_waddr          = r_slot;
        w_wdata          = '0;
        w_alloc_ctl.len  = r_len;
        w_alloc_ctl.commit = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                n_slot = r_slot + hira_pkg::SLOT_BITS'(1);
                if (r_slot == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_func   = i_s_tuser;
                    n_key    = i_s_tdata[hira_pkg::KEY_BITS-1:0];
                    n_len    = hira_pkg::LEN_BITS'(2) + {w_acts, 1'b0};
                    n_slot   = i_s_tdata[hira_pkg::SLOT_BITS-1:0];
                    n_misses = '0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                n_pos = '0;
                priority if (!w_entry.used) begin
                    n_state  = S_DONE;
                    n_status = hira_pkg::ST_ABSENT;
                    if (r_func && r_adding_en) begin
                        if (w_alloc_sts.fits) begin
                            n_status           = hira_pkg::ST_INSERTED;
                            n_pos              = w_alloc_sts.pos;
                            w_alloc_ctl.commit = 1'b1;
                            w_we               = 1'b1;
                            w_wdata.used       = 1'b1;
                            w_wdata.pos        = w_alloc_sts.pos;
                            w_wdata.key        = r_key;
                        end else begin
                            n_status = hira_pkg::ST_STORE_FULL;
                        end
                    end
                end else if (w_entry.key == r_key) begin
                    n_state  = S_DONE;
                    n_status = hira_pkg::ST_FOUND;
                    n_pos    = w_entry.pos;
                end else if (r_misses == LAST_SLOT) begin
                    n_state  = S_DONE;
                    n_status = hira_pkg::ST_INDEX_FULL;
                end else begin
                    n_slot   = r_slot + hira_pkg::SLOT_BITS'(1);
                    n_misses = r_misses + hira_pkg::SLOT_BITS'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_data   = {4'b0000, r_misses, r_slot, r_pos};
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_slot  = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_misses     <= n_misses;
        r_func       <= n_func;
        r_key        <= n_key;
        r_len        <= n_len;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_words <= hira_pkg::STORE_BITS'(1) << hira_pkg::POS_BITS;
            r_adding_en   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hira_pkg::CFG_STORE_WORDS: r_store_words <= i_cfg_wdata;
                hira_pkg::CFG_ADDING_EN:   r_adding_en   <= i_cfg_wdata[0];
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

endmodule

[tb/sv/tb.sv]
module tb;

    // request kinds carried on the request tuser
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic [hira_pkg::STORE_BITS-1:0] STORE_MAX =
        hira_pkg::STORE_BITS'(1) << hira_pkg::POS_BITS;
    localparam int                    TIMEOUT_CYCLES = 1_000_000;

    typedef struct {
        hira_pkg::t_status                status;
        logic [hira_pkg::POS_BITS-1:0]    position;
        logic [hira_pkg::SLOT_BITS-1:0]   slot;
        logic [hira_pkg::SLOT_BITS-1:0]   misses;
    } t_result;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    logic [71:0]                     req_data = '0;
    logic                            req_func = FUNC_LOOKUP;
    logic                            res_valid;
    logic                            res_ready = 1'b0;
    logic [47:0]                     res_data;
    logic [hira_pkg::STAT_BITS-1:0]  res_status;
    logic                            cfg_we = 1'b0;
    logic                            cfg_addr = hira_pkg::CFG_STORE_WORDS;
    logic [hira_pkg::STORE_BITS-1:0] cfg_wdata = '0;

    // predicted index and allocator state
    logic [hira_pkg::KEY_BITS-1:0]   model_keys [hira_pkg::INDEX_DEPTH];
    logic [hira_pkg::POS_BITS-1:0]   model_pos [hira_pkg::INDEX_DEPTH];
    bit                              model_used [hira_pkg::INDEX_DEPTH];
    logic [25:0]                     model_next_free = '0;
    logic [hira_pkg::STORE_BITS-1:0] model_store_words = STORE_MAX;
    bit                              model_adding = 1'b1;

    t_result                         pending_results [$];
    logic [hira_pkg::KEY_BITS-1:0]   seen_keys [$];
    int                              mismatch_count = 0;
    bit                              idle_on = 1'b1;
    int                              hold_cycles = 0;

    hash_index_record_allocator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (req_valid),
        .o_s_tready  (req_ready),
        .i_s_tdata   (req_data),
        .i_s_tuser   (req_func),
        .o_m_tvalid  (res_valid),
        .i_m_tready  (res_ready),
        .o_m_tdata   (res_data),
        .o_m_tuser   (res_status),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // probe the predicted index and allocate on an insert of an unseen key if adding is on and it fits
    function automatic t_result lookup_or_allocate(input logic func, input logic [63:0] key,
                                                   input logic [hira_pkg::ACT_BITS-1:0] acts);
        logic [hira_pkg::SLOT_BITS-1:0] slot;
        int                             misses;
        bit                             hit;
        bit                             empty;
        bit                             full;
        logic [hira_pkg::ACT_BITS-1:0]  count;
        logic [25:0]                    len;
        logic [25:0]                    limit;
        t_result                        r;
        slot = key[hira_pkg::SLOT_BITS-1:0];
        misses = 0;
        hit = 1'b0;
        empty = 1'b0;
        full = 1'b0;
        count = acts;
        if (count < hira_pkg::MIN_ACTIONS) count = hira_pkg::MIN_ACTIONS;
        if (count > hira_pkg::MAX_ACTIONS) count = hira_pkg::MAX_ACTIONS;
        // linear probe, wrapping at the top of the index
        while (!hit && !empty && !full) begin
            if (!model_used[slot]) begin
                empty = 1'b1;
            end else if (model_keys[slot] == key) begin
                hit = 1'b1;
            end else if (misses == hira_pkg::INDEX_DEPTH - 1) begin
                full = 1'b1;
            end else begin
                misses++;
                slot = slot + 1'b1;
            end
        end
        r.status = hira_pkg::ST_INDEX_FULL;
        r.position = '0;
        r.slot = slot;
        r.misses = hira_pkg::SLOT_BITS'(misses);
        if (hit) begin
            r.status = hira_pkg::ST_FOUND;
            r.position = model_pos[slot];
        end else if (empty) begin
            r.status = hira_pkg::ST_ABSENT;
            if (func == FUNC_INSERT && model_adding) begin
                len = 26'd2 + 26'd2 * 26'(count);
                limit = (model_store_words < STORE_MAX) ? 26'(model_store_words)
                                                        : 26'(STORE_MAX);
                if (model_next_free + len > limit) begin
                    r.status = hira_pkg::ST_STORE_FULL;
                end else begin
                    model_used[slot] = 1'b1;
                    model_keys[slot] = key;
                    model_pos[slot] = model_next_free[hira_pkg::POS_BITS-1:0];
                    r.position = model_next_free[hira_pkg::POS_BITS-1:0];
                    model_next_free = model_next_free + len;
                    r.status = hira_pkg::ST_INSERTED;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // one request beat, with a random gap ahead of it
    task automatic send_request(input logic func, input logic [63:0] key,
                                input logic [hira_pkg::ACT_BITS-1:0] acts);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= {1'b0, acts, key};
        req_func <= func;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pending_results.push_back(lookup_or_allocate(func, key, acts));
        seen_keys.push_back(key);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic addr,
                                  input logic [hira_pkg::STORE_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (addr == hira_pkg::CFG_STORE_WORDS)
            model_store_words = value;
        else
            model_adding = value[0];
    endtask

    // mostly legal counts, sometimes zero or above the clamp
    function automatic logic [hira_pkg::ACT_BITS-1:0] draw_actions();
        int unsigned c;
        c = $urandom_range(0, 19);
        case (c)
            0: return '0;
            1: return hira_pkg::ACT_BITS'($urandom_range(65, 127));
            2: return hira_pkg::MAX_ACTIONS;
            3: return hira_pkg::MIN_ACTIONS;
            default: return hira_pkg::ACT_BITS'($urandom_range(1, 64));
        endcase
    endfunction

    // reuse an old key, crowd a window of home slots, or go fully random
    function automatic logic [63:0] pick_key(input int unsigned base);
        logic [63:0] k;
        int unsigned c;
        k = {$urandom, $urandom};
        c = $urandom_range(0, 9);
        if (c <= 3 && seen_keys.size() > 0)
            k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        else if (c <= 6)
            k[hira_pkg::SLOT_BITS-1:0] = hira_pkg::SLOT_BITS'(base + $urandom_range(0, 15));
        return k;
    endfunction

    task automatic test_basic_lookup_insert();
        logic [63:0] wrap_key;
        wrap_key = {$urandom, $urandom} | 64'h3ff;
        wrap_key[63] = 1'b0;
        send_request(FUNC_LOOKUP, 64'd0, 7'd1);
        send_request(FUNC_INSERT, 64'd0, 7'd0);
        send_request(FUNC_LOOKUP, 64'd0, 7'd5);
        send_request(FUNC_INSERT, 64'd0, hira_pkg::MAX_ACTIONS);
        send_request(FUNC_INSERT, '1, 7'd127);
        // home at the top slot, probe wraps past slot zero
        send_request(FUNC_INSERT, wrap_key, hira_pkg::MAX_ACTIONS);
        send_request(FUNC_LOOKUP, wrap_key, 7'd1);
        send_request(FUNC_INSERT, {$urandom, $urandom}, 7'd65);
        send_request(FUNC_LOOKUP, 64'h8000_0000_0000_03ff, 7'd1);
    endtask

    task automatic test_adding_disabled();
        drain_results();
        write_register(hira_pkg::CFG_ADDING_EN, 25'd0);
        send_request(FUNC_INSERT, {$urandom, $urandom}, 7'd3);
        send_request(FUNC_INSERT, 64'd0, 7'd3);
        send_request(FUNC_LOOKUP, '1, 7'd1);
        drain_results();
        write_register(hira_pkg::CFG_ADDING_EN, 25'd1);
    endtask

    task automatic test_store_full();
        write_register(hira_pkg::CFG_STORE_WORDS, 25'd1);
        send_request(FUNC_INSERT, {$urandom, $urandom}, 7'd1);
        // a small store does not hide records already placed
        send_request(FUNC_LOOKUP, 64'd0, 7'd1);
        drain_results();
        // room for exactly one short record
        write_register(hira_pkg::CFG_STORE_WORDS,
                       hira_pkg::STORE_BITS'(model_next_free + 26'd4));
        send_request(FUNC_INSERT, {$urandom, $urandom}, 7'd1);
        send_request(FUNC_INSERT, {$urandom, $urandom}, 7'd1);
        drain_results();
        write_register(hira_pkg::CFG_STORE_WORDS, STORE_MAX);
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_cycles = 300;
        repeat (24) send_request(FUNC_INSERT, {$urandom, $urandom}, draw_actions());
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned base;
        int unsigned c;
        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            write_register(hira_pkg::CFG_ADDING_EN,
                           (phase == 0) ? 25'd1 : 25'($urandom_range(0, 3) != 0));
            c = (phase == 0) ? 0 : $urandom_range(0, 2);
            case (c)
                0: write_register(hira_pkg::CFG_STORE_WORDS, STORE_MAX);
                1: write_register(hira_pkg::CFG_STORE_WORDS,
                                  hira_pkg::STORE_BITS'(model_next_free +
                                                        $urandom_range(1, 3000)));
                default: write_register(hira_pkg::CFG_STORE_WORDS,
                                        hira_pkg::STORE_BITS'($urandom_range(1, STORE_MAX)));
            endcase
            idle_on = (phase != 2);
            base = $urandom_range(0, hira_pkg::INDEX_DEPTH - 1);
            repeat (100)
                send_request(($urandom_range(0, 9) < 7) ? FUNC_INSERT : FUNC_LOOKUP,
                             pick_key(base), draw_actions());
        end
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_index_full();
        logic [63:0] k;
        write_register(hira_pkg::CFG_STORE_WORDS, STORE_MAX);
        write_register(hira_pkg::CFG_ADDING_EN, 25'd1);
        // fill every empty slot at its own home, no probing
        idle_on = 1'b0;
        for (int s = 0; s < hira_pkg::INDEX_DEPTH; s++) begin
            if (!model_used[s]) begin
                k = {$urandom, $urandom};
                k[hira_pkg::SLOT_BITS-1:0] = hira_pkg::SLOT_BITS'(s);
                send_request(FUNC_INSERT, k, 7'd1);
            end
        end
        idle_on = 1'b1;
        send_request(FUNC_LOOKUP, {$urandom, $urandom}, 7'd1);
        send_request(FUNC_INSERT, {$urandom, $urandom}, hira_pkg::MAX_ACTIONS);
        send_request(FUNC_LOOKUP, model_keys[$urandom_range(0, hira_pkg::INDEX_DEPTH - 1)],
                     7'd1);
        send_request(FUNC_INSERT, '1, 7'd2);
    endtask

    // result side: random stalls, long hold on request, check every beat
    initial begin : result_checker
        t_result want;
        int      stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_cycles > 0) begin
                res_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 11) : 0;
                if (stall > 0) begin
                    res_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 64'(res_data), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (res_status !== want.status)
                    report_mismatch("status", 64'(res_status), 64'(want.status));
                if (res_data[23:0] !== want.position)
                    report_mismatch("position", 64'(res_data[23:0]), 64'(want.position));
                if (res_data[33:24] !== want.slot)
                    report_mismatch("slot", 64'(res_data[33:24]), 64'(want.slot));
                if (res_data[43:34] !== want.misses)
                    report_mismatch("probe_misses", 64'(res_data[43:34]), 64'(want.misses));
            end
        end
    end

    initial begin : watchdog
        #(8 * TIMEOUT_CYCLES);
        $display("tb NOT OK");
        $finish;
    end

    initial begin : run
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_lookup_insert();
        test_adding_disabled();
        test_store_full();
        test_backpressure();
        test_random_traffic();
        test_index_full();
        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/hira_pkg.sv
sv/hira_slot_mem.sv
sv/hira_alloc.sv
sv/hash_index_record_allocator.sv
tb/sv/tb.sv
